@@ hdl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the symbol frequency rank block
// Request action codes, fixed payload widths and controller/datapath structs.
// ----------------------------------------------------------------------------
package sfr_pkg;

	// Payload field widths
	localparam int SYM_W     = 8;
	localparam int CNT_OUT_W = 16;
	localparam int TOT_OUT_W = 24;

	// String terminator byte, never counted
	localparam logic [SYM_W-1:0] TERMINATOR = 8'd0;

	// Request action codes
	typedef enum logic [1:0] {
		ACT_COUNT = 2'd0,
		ACT_RANK  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Controller to datapath commands
	typedef struct packed {
		logic count_start;  // latch symbol check, histogram read issued
		logic count_wr;     // write incremented count back
		logic scan_start;   // reset scan pointer and best candidate
		logic scan;         // read one histogram entry, advance pointer
		logic finish;       // commit rank result and load output
		logic clear;        // empty histogram, taken marks and total
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_last;    // scan pointer is at the last entry
		logic out_free;     // output register can take a result this cycle
	} status_t;

endpackage

@@ hdl/sfr_req_if.sv @@
// ----------------------------------------------------------------------------
// sfr_req_if: request channel
// Valid/ready channel carrying one action and one symbol per request.
// ----------------------------------------------------------------------------
interface sfr_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] symbol;

	modport source (output valid, output action, output symbol, input ready);
	modport sink   (input valid, input action, input symbol, output ready);
endinterface

@@ hdl/sfr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sfr_rsp_if: rank result channel
// Valid/ready channel carrying one ranked symbol result.
// ----------------------------------------------------------------------------
interface sfr_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  ranked_symbol;
	logic [15:0] symbol_count;
	logic [23:0] running_total;
	logic        exhausted;

	modport source (output valid, output ranked_symbol, output symbol_count,
		output running_total, output exhausted, input ready);
	modport sink   (input valid, input ranked_symbol, input symbol_count,
		input running_total, input exhausted, output ready);
endinterface

@@ hdl/sfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfr_ctrl: sequencing controller
// Accepts one request at a time and steps the datapath through count,
// scan and commit phases.
// ----------------------------------------------------------------------------
module sfr_ctrl
	import sfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_action,
	output logic       req_ready,
	input  status_t    status,
	output cmd_t       cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CNT_WR = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_nxt;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	// Next state and command decode
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action_t'(req_action))
						ACT_COUNT: begin
							cmd.count_start = 1'b1;
							state_nxt       = ST_CNT_WR;
						end
						ACT_RANK: begin
							cmd.scan_start = 1'b1;
							state_nxt      = ST_SCAN;
						end
						ACT_CLEAR: cmd.clear = 1'b1;
						default:   state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_CNT_WR: begin
				cmd.count_wr = 1'b1;
				state_nxt    = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) state_nxt = ST_DRAIN;
			end
			// last entry is compared here
			ST_DRAIN: state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ hdl/sfr_datapath.sv @@
// ----------------------------------------------------------------------------
// sfr_datapath: histogram memory, scan comparator and result register
// One histogram read per cycle; counts update by read-modify-write, a rank
// scan walks every entry keeping the largest untaken count.
// ----------------------------------------------------------------------------
module sfr_datapath
	import sfr_pkg::*;
#(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_BITS    = 16,
	parameter int TOTAL_BITS    = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic [SYM_W-1:0]     req_symbol,
	input  logic                 rsp_ready,
	output logic                 rsp_valid,
	output logic [SYM_W-1:0]     rsp_symbol,
	output logic [CNT_OUT_W-1:0] rsp_count,
	output logic [TOT_OUT_W-1:0] rsp_total,
	output logic                 rsp_exhausted
);

	localparam int IDX_W = $clog2(ALPHABET_SIZE);
	localparam int SUM_W = ((TOTAL_BITS > COUNT_BITS) ? TOTAL_BITS : COUNT_BITS) + 1;
	localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ALPHABET_SIZE - 1);
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

	// Histogram storage; valid bits stand in for the cleared state
	logic [COUNT_BITS-1:0]    hist_mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] hist_vld_q;
	logic [ALPHABET_SIZE-1:0] taken_q;

	logic [IDX_W-1:0]      scan_idx_q;
	logic [IDX_W-1:0]      rd_addr;
	logic [COUNT_BITS-1:0] rd_data_s1;
	logic                  hv_s1;
	logic                  tk_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  scan_s1;

	logic                  sym_ok;
	logic                  cnt_ok_q;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic                  cnt_inc;

	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic                  found_q;
	logic                  hit;

	logic [TOTAL_BITS-1:0] total_q;
	logic [SUM_W-1:0]      sum;
	logic [TOTAL_BITS-1:0] total_nxt;
	logic                  out_valid_q;

	// Read address: scan pointer during a scan, request symbol otherwise
	assign rd_addr = cmd.scan ? scan_idx_q : req_symbol[IDX_W-1:0];

	// Terminator and out-of-alphabet bytes are not counted
	assign sym_ok = (req_symbol != TERMINATOR) &&
		({1'b0, req_symbol} < (SYM_W + 1)'(ALPHABET_SIZE));

	// Registered read stage
	always_ff @(posedge clk) begin
		rd_data_s1 <= hist_mem[rd_addr];
		hv_s1      <= hist_vld_q[rd_addr];
		tk_s1      <= taken_q[rd_addr];
		idx_s1     <= rd_addr;
	end

	// Count increment, saturating
	assign cur_cnt = hv_s1 ? rd_data_s1 : '0;
	assign cnt_inc = cmd.count_wr && cnt_ok_q && (cur_cnt != '1);

	always_ff @(posedge clk) begin
		if (cnt_inc) hist_mem[idx_s1] <= cur_cnt + COUNT_BITS'(1);
		if (cmd.count_start) cnt_ok_q <= sym_ok;
	end

	// Valid bits and taken marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			taken_q    <= '0;
		end else if (cmd.clear) begin
			hist_vld_q <= '0;
			taken_q    <= '0;
		end else begin
			if (cnt_inc) hist_vld_q[idx_s1] <= 1'b1;
			if (cmd.finish && found_q) taken_q[best_idx_q] <= 1'b1;
		end
	end

	// Scan pointer and compare-stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			scan_s1    <= 1'b0;
		end else begin
			scan_s1 <= cmd.scan;
			if (cmd.scan_start) scan_idx_q <= '0;
			else if (cmd.scan && (scan_idx_q != LAST_IDX)) scan_idx_q <= scan_idx_q + IDX_W'(1);
		end
	end

	assign status.scan_last = (scan_idx_q == LAST_IDX);

	// Best candidate: strict compare keeps the lower byte on ties
	assign hit = scan_s1 && hv_s1 && !tk_s1 && (rd_data_s1 > best_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_start) begin
			found_q <= 1'b0;
		end else if (hit) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			best_cnt_q <= '0;
		end else if (hit) begin
			best_cnt_q <= rd_data_s1;
			best_idx_q <= idx_s1;
		end
	end

	// Saturating running total
	assign sum       = SUM_W'(total_q) + SUM_W'(best_cnt_q);
	assign total_nxt = (sum >= SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.clear) begin
			total_q <= '0;
		end else if (cmd.finish && found_q) begin
			total_q <= total_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_symbol    <= found_q ? SYM_W'(best_idx_q) : '0;
			rsp_count     <= found_q ? CNT_OUT_W'(best_cnt_q) : '0;
			rsp_total     <= TOT_OUT_W'(found_q ? total_nxt : total_q);
			rsp_exhausted <= !found_q;
		end
	end

	assign rsp_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || rsp_ready;

endmodule

@@ hdl/symbol_frequency_rank.sv @@
// ----------------------------------------------------------------------------
// symbol_frequency_rank: byte histogram with ranked symbol extraction
// A count request adds one occurrence of a byte (byte 0 is ignored) to a
// saturating per-symbol histogram. A clear request empties the histogram,
// taken marks and running total. A rank request returns the untaken symbol
// with the largest nonzero count (ties to the lower byte), marks it taken and
// adds its count to a saturating running total; with nothing left it returns
// exhausted. A rank request scans the whole histogram, reading one histogram
// memory entry per cycle through a single read port, and its commit also
// waits while the previous result waits on the result channel. One request
// is in work at a time; a new request is taken while a result waits to be
// taken.
// ----------------------------------------------------------------------------
module symbol_frequency_rank
	import sfr_pkg::*;
#(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_BITS    = 16,
	parameter int TOTAL_BITS    = 24
) (
	input logic     clk,
	input logic     arst_n,
	sfr_req_if.sink   req,
	sfr_rsp_if.source rsp
);

	cmd_t    cmd;
	status_t status;

	// Controller
	sfr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.status     (status),
		.cmd        (cmd)
	);

	// Datapath
	sfr_datapath #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.COUNT_BITS    (COUNT_BITS),
		.TOTAL_BITS    (TOTAL_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.req_symbol    (req.symbol),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp.valid),
		.rsp_symbol    (rsp.ranked_symbol),
		.rsp_count     (rsp.symbol_count),
		.rsp_total     (rsp.running_total),
		.rsp_exhausted (rsp.exhausted)
	);

	// A result is never committed over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> status.out_free)
		else $error("rank result committed while output busy");

	// Datapath operations never overlap
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.count_wr, cmd.scan, cmd.finish, cmd.clear}))
		else $error("overlapping datapath commands");

	// Scan stops after the last entry
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan && status.scan_last |=> !cmd.scan)
		else $error("scan ran past last entry");

	// Exhausted result carries zero symbol and count
	a_exhausted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.exhausted |-> (rsp.ranked_symbol == '0) && (rsp.symbol_count == '0))
		else $error("exhausted result with nonzero payload");

endmodule

@@ test/symbol_frequency_rank_tb.sv @@
// ----------------------------------------------------------------------------
// symbol_frequency_rank_tb: self-checking bench for the symbol frequency rank
// A table of directed requests runs first: empty ranks after reset, the
// terminator byte, ties, taken symbols and repeated counts of one byte. Then
// rounds of random counts and ranks follow. Every rank result is checked
// field by field against the table's typed expectation or else an in-bench
// histogram model, under changing idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module symbol_frequency_rank_tb
	import sfr_pkg::*;
();

	localparam int ALPHABET    = 256;
	localparam int RANDOM_REQS = 700;
	localparam int PHASE_REQS  = 75;
	localparam int TAIL_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 3_000_000;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [23:0] TOTAL_MAX = 24'hFF_FFFF;

	// One rank result
	typedef struct packed {
		logic [7:0]  sym;
		logic [15:0] cnt;
		logic [23:0] total;
		logic        exhausted;
	} rank_t;

	// Directed table row; want is used only when typed is set
	typedef struct packed {
		action_t     act;
		logic [7:0]  sym;
		logic [16:0] reps;
		logic        typed;
		rank_t       want;
	} dir_row_t;

	// Per-request note from the driver: a typed expectation, if any
	typedef struct packed {
		logic  typed;
		rank_t want;
	} req_note_t;

	localparam rank_t NO_RANK = '0;
	localparam int DIR_ROWS = 25;

	localparam dir_row_t dir_table [DIR_ROWS] = '{
		// empty histogram right after reset
		'{ACT_RANK,  8'h00, 17'd1, 1'b1, '{8'h00, 16'd0, 24'd0, 1'b1}},
		// terminator byte is never counted
		'{ACT_COUNT, 8'h00, 17'd1, 1'b0, NO_RANK},
		'{ACT_RANK,  8'h00, 17'd1, 1'b1, '{8'h00, 16'd0, 24'd0, 1'b1}},
		'{ACT_COUNT, 8'hFF, 17'd1, 1'b0, NO_RANK},
		'{ACT_COUNT, 8'h01, 17'd2, 1'b0, NO_RANK},
		'{ACT_COUNT, 8'h80, 17'd1, 1'b0, NO_RANK},
		// unused action does nothing
		'{ACT_NONE,  8'hFF, 17'd1, 1'b0, NO_RANK},
		'{ACT_RANK,  8'h00, 17'd1, 1'b1, '{8'h01, 16'd2, 24'd2, 1'b0}},
		// tie between 0x80 and 0xFF goes to the lower byte
		'{ACT_RANK,  8'h00, 17'd1, 1'b1, '{8'h80, 16'd1, 24'd3, 1'b0}},
		// taken symbol keeps counting but is not returned again
		'{ACT_COUNT, 8'h01, 17'd1, 1'b0, NO_RANK},
		'{ACT_RANK,  8'h00, 17'd1, 1'b1, '{8'hFF, 16'd1, 24'd4, 1'b0}},
		'{ACT_RANK,  8'h00, 17'd1, 1'b1, '{8'h00, 16'd0, 24'd4, 1'b1}},
		'{ACT_CLEAR, 8'h00, 17'd1, 1'b0, NO_RANK},
		'{ACT_RANK,  8'h00, 17'd1, 1'b1, '{8'h00, 16'd0, 24'd0, 1'b1}},
		'{ACT_COUNT, 8'hAA, 17'd3, 1'b0, NO_RANK},
		'{ACT_COUNT, 8'h55, 17'd3, 1'b0, NO_RANK},
		'{ACT_COUNT, 8'h0F, 17'd1, 1'b0, NO_RANK},
		'{ACT_RANK,  8'h00, 17'd1, 1'b0, NO_RANK},
		'{ACT_RANK,  8'h00, 17'd1, 1'b0, NO_RANK},
		'{ACT_RANK,  8'h00, 17'd1, 1'b0, NO_RANK},
		'{ACT_CLEAR, 8'h00, 17'd1, 1'b0, NO_RANK},
		// repeated counts of one byte
		'{ACT_COUNT, 8'hFE, 17'd5, 1'b0, NO_RANK},
		'{ACT_COUNT, 8'h7F, 17'd1, 1'b0, NO_RANK},
		'{ACT_RANK,  8'h00, 17'd1, 1'b1, '{8'hFE, 16'd5, 24'd5, 1'b0}},
		'{ACT_RANK,  8'h00, 17'd1, 1'b1, '{8'h7F, 16'd1, 24'd6, 1'b0}}
	};

	logic clk;
	logic arst_n;

	sfr_req_if req_ch ();
	sfr_rsp_if rsp_ch ();

	symbol_frequency_rank DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// Histogram model state
	logic [15:0] hist_count [ALPHABET] = '{default: '0};
	logic        taken_mark [ALPHABET] = '{default: 1'b0};
	logic [23:0] weight_total = '0;

	rank_t     rank_expect_q [$];
	req_note_t req_note_q [$];

	int     errors = 0;
	longint cycles = 0;
	int     send_idle_pct = 0;
	int     take_stall_pct = 0;

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Apply one request to the model; returns 1 when it yields a rank result
	function automatic bit apply_request(input action_t act, input logic [7:0] sym,
			output rank_t res);
		int          best;
		logic [15:0] best_cnt;
		logic [24:0] sum;
		res = '0;
		best = 0;
		best_cnt = '0;
		case (act)
			ACT_COUNT: begin
				if (sym != TERMINATOR && hist_count[sym] != COUNT_MAX)
					hist_count[sym] = hist_count[sym] + 16'd1;
				return 1'b0;
			end
			ACT_CLEAR: begin
				for (int i = 0; i < ALPHABET; i++) begin
					hist_count[i] = '0;
					taken_mark[i] = 1'b0;
				end
				weight_total = '0;
				return 1'b0;
			end
			ACT_RANK: begin
				// strict compare keeps the lowest byte on ties
				for (int i = 0; i < ALPHABET; i++) begin
					if (!taken_mark[i] && hist_count[i] > best_cnt) begin
						best = i;
						best_cnt = hist_count[i];
					end
				end
				if (best_cnt == 0) begin
					res.exhausted = 1'b1;
				end else begin
					taken_mark[best] = 1'b1;
					sum = {1'b0, weight_total} + best_cnt;
					weight_total = (sum >= TOTAL_MAX) ? TOTAL_MAX : sum[23:0];
					res.sym = best[7:0];
					res.cnt = best_cnt;
				end
				res.total = weight_total;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, want %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	// Receiver ready pattern
	always @(posedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= take_stall_pct);

	// Track accepted requests and check accepted results
	always @(posedge clk) begin
		rank_t     predicted;
		rank_t     want;
		req_note_t note;
		bit        has_rank;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			has_rank = apply_request(action_t'(req_ch.action), req_ch.symbol, predicted);
			note = '0;
			if (req_note_q.size() != 0)
				note = req_note_q.pop_front();
			if (has_rank)
				rank_expect_q.insert(rank_expect_q.size(),
					note.typed ? note.want : predicted);
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (rank_expect_q.size() == 0) begin
				report_mismatch("result with none pending, symbol", rsp_ch.ranked_symbol, 0);
			end else begin
				want = rank_expect_q.pop_front();
				if (rsp_ch.ranked_symbol !== want.sym)
					report_mismatch("ranked_symbol", rsp_ch.ranked_symbol, want.sym);
				if (rsp_ch.symbol_count !== want.cnt)
					report_mismatch("symbol_count", rsp_ch.symbol_count, want.cnt);
				if (rsp_ch.running_total !== want.total)
					report_mismatch("running_total", rsp_ch.running_total, want.total);
				if (rsp_ch.exhausted !== want.exhausted)
					report_mismatch("exhausted", rsp_ch.exhausted, want.exhausted);
			end
		end
	end

	// Send one request, with a random idle gap in front of it
	task automatic send_req(input action_t act, input logic [7:0] sym,
			input logic typed = 1'b0, input rank_t want = '0);
		int        gap;
		req_note_t note;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.action <= act;
		req_ch.symbol <= sym;
		note = '{typed, want};
		req_note_q.insert(req_note_q.size(), note);
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Wait on the clock first so the monitor has logged the last accepted request
	task automatic wait_all_ranked();
		@(posedge clk);
		while (rank_expect_q.size() != 0) @(posedge clk);
	endtask

	// Stimulus
	initial begin
		logic [7:0] pool [6];
		int         pool_n;
		int         live;
		int         phase;
		int         roll;
		logic [7:0] sym;
		req_ch.valid  <= 1'b0;
		req_ch.action <= ACT_NONE;
		req_ch.symbol <= '0;
		arst_n        <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (dir_table[r])
			repeat (dir_table[r].reps)
				send_req(dir_table[r].act, dir_table[r].sym, dir_table[r].typed,
					dir_table[r].want);

		// Random rounds: an optional clear, counts mostly from a small pool of symbols, then ranks
		live = 0;
		phase = 0;
		while (live < RANDOM_REQS) begin
			if (live / PHASE_REQS != phase) begin
				// hold off until every rank result is back, then change pattern
				req_ch.valid <= 1'b0;
				wait_all_ranked();
				phase = live / PHASE_REQS;
				case (phase % 4)
					0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
					1: begin send_idle_pct = 58; take_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  take_stall_pct = 58; end
					default: begin send_idle_pct = 11; take_stall_pct = 11; end
				endcase
			end
			if ($urandom_range(3) == 0) begin
				send_req(ACT_CLEAR, 8'($urandom_range(255)));
				live++;
			end
			pool_n = $urandom_range(1, 6);
			for (int k = 0; k < 6; k++)
				pool[k] = 8'($urandom_range(1, 255));
			repeat ($urandom_range(1, 30)) begin
				roll = $urandom_range(99);
				if (roll < 5) begin
					send_req(ACT_NONE, 8'($urandom_range(255)));
				end else if (roll < 15) begin
					sym = 8'($urandom_range(255));
					send_req(ACT_COUNT, sym);
					if (sym != TERMINATOR)
						live++;
				end else begin
					send_req(ACT_COUNT, pool[$urandom_range(0, pool_n - 1)]);
					live++;
				end
			end
			// sometimes more ranks than symbols, to run the histogram dry
			repeat ($urandom_range(1, pool_n + 2)) begin
				send_req(ACT_RANK, 8'($urandom_range(255)));
				live++;
			end
		end
		req_ch.valid <= 1'b0;

		// Drain and let any stray result show up
		wait_all_ranked();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && rank_expect_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
